// ===== rtl/rc4_feedback_stream_cipher_defines.svh =====
// ----------------------------------------------------------------------------
// rc4 feedback stream cipher assertion macros
// shared concurrent assertion forms for the rtl
// ----------------------------------------------------------------------------
`ifndef RC4_FEEDBACK_STREAM_CIPHER_DEFINES_SVH
`define RC4_FEEDBACK_STREAM_CIPHER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define RC4FB_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// implication with the consequent checked ##n after the antecedent, disabled during reset
`define RC4FB_ASSERT_AFTER(lbl, clk, rst, ante, n, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
      else $error(msg);

`endif

// ===== rtl/rc4fb_pkg.sv =====
// ----------------------------------------------------------------------------
// rc4fb_pkg
// shared constants, datapath operation codes and control structs
// ----------------------------------------------------------------------------
package rc4fb_pkg;

   localparam int BYTE_W            = 8;
   localparam int PERM_DEPTH        = 256;
   localparam int PERM_AW           = 8;
   localparam int DEF_MAX_KEY_BYTES = 32;

   localparam logic KIND_KEY  = 1'b0;
   localparam logic KIND_DATA = 1'b1;

   localparam logic DIR_DECRYPT = 1'b0;
   localparam logic DIR_ENCRYPT = 1'b1;

   typedef enum logic [3:0] {
      OP_IDLE,
      OP_KEY,
      OP_DATA_START,
      OP_DATA_J,
      OP_DATA_SWAP,
      OP_DATA_OUT,
      OP_DATA_HOLD,
      OP_FILL,
      OP_MIX_RD,
      OP_MIX_J,
      OP_MIX_SW,
      OP_MIX_WR,
      OP_FB_LD
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      load_rsp;
   } dp_cmd_type;

   typedef struct packed {
      logic k_last;
      logic rsp_busy;
   } dp_status_type;

endpackage

// ===== rtl/rc4fb_ram.sv =====
// ----------------------------------------------------------------------------
// rc4fb_ram
// generic one-write one-read ram, registered read returning old data
// ----------------------------------------------------------------------------
module rc4fb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/rc4fb_ctrl.sv =====
// ----------------------------------------------------------------------------
// rc4fb_ctrl
// sequencer for table init, key schedule and per-byte cipher steps
// ----------------------------------------------------------------------------
module rc4fb_ctrl
   import rc4fb_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_kind,
   input  logic          req_last,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_DATA_J,
      ST_DATA_SWAP,
      ST_DATA_OUT,
      ST_DATA_HOLD,
      ST_SCHED_FILL,
      ST_MIX_RD,
      ST_MIX_J,
      ST_MIX_SW,
      ST_MIX_WR,
      ST_FB_LD
   } state_type;

   state_type state_ff, state_in;
   logic      fire;

   assign req_ready = (state_ff == ST_IDLE);
   assign fire      = req_valid && req_ready;

   always_comb begin
      state_in     = state_ff;
      cmd.op       = OP_IDLE;
      cmd.load_rsp = 1'b0;
      case (state_ff)
         ST_INIT: begin
            cmd.op = OP_FILL;
            if (status.k_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (fire) begin
               if (req_kind == KIND_DATA) begin
                  cmd.op   = OP_DATA_START;
                  state_in = ST_DATA_J;
               end else begin
                  cmd.op = OP_KEY;
                  if (req_last) state_in = ST_SCHED_FILL;
               end
            end
         end
         ST_DATA_J: begin
            cmd.op   = OP_DATA_J;
            state_in = ST_DATA_SWAP;
         end
         ST_DATA_SWAP: begin
            cmd.op   = OP_DATA_SWAP;
            state_in = ST_DATA_OUT;
         end
         ST_DATA_OUT: begin
            cmd.op       = OP_DATA_OUT;
            cmd.load_rsp = !status.rsp_busy;
            state_in     = status.rsp_busy ? ST_DATA_HOLD : ST_IDLE;
         end
         ST_DATA_HOLD: begin
            cmd.op       = OP_DATA_HOLD;
            cmd.load_rsp = !status.rsp_busy;
            state_in     = status.rsp_busy ? ST_DATA_HOLD : ST_IDLE;
         end
         ST_SCHED_FILL: begin
            cmd.op = OP_FILL;
            if (status.k_last) state_in = ST_MIX_RD;
         end
         ST_MIX_RD: begin
            cmd.op   = OP_MIX_RD;
            state_in = ST_MIX_J;
         end
         ST_MIX_J: begin
            cmd.op   = OP_MIX_J;
            state_in = ST_MIX_SW;
         end
         ST_MIX_SW: begin
            cmd.op   = OP_MIX_SW;
            state_in = ST_MIX_WR;
         end
         ST_MIX_WR: begin
            cmd.op   = OP_MIX_WR;
            state_in = status.k_last ? ST_FB_LD : ST_MIX_RD;
         end
         ST_FB_LD: begin
            cmd.op   = OP_FB_LD;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/rc4fb_dp.sv =====
// ----------------------------------------------------------------------------
// rc4fb_dp
// permutation and key memories, indices, feedback and result register
// ----------------------------------------------------------------------------
`include "rc4_feedback_stream_cipher_defines.svh"

module rc4fb_dp
   import rc4fb_pkg::*;
#(
   parameter int MAX_KEY_BYTES = DEF_MAX_KEY_BYTES,
   localparam int KAW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1,
   localparam int KCW = $clog2(MAX_KEY_BYTES + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  dp_cmd_type        cmd,
   output dp_status_type     status,
   input  logic [BYTE_W-1:0] req_in_byte,
   input  logic              csr_we,
   input  logic              csr_direction,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [BYTE_W-1:0] rsp_out_byte
);

   logic [KCW-1:0]     count_ff, count_in;
   logic [KCW-1:0]     kidx_ff, kidx_in;
   logic [KCW-1:0]     kidx_inc;
   logic [PERM_AW-1:0] k_ff, k_in;
   logic [BYTE_W-1:0]  i_ff, i_in;
   logic [BYTE_W-1:0]  j_ff, j_in;
   logic [BYTE_W-1:0]  fb_ff, fb_in;
   logic               dir_ff, dir_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]  ti_ff, ti_in;
   logic [BYTE_W-1:0]  tj_ff, tj_in;
   logic [BYTE_W-1:0]  byte_ff, byte_in;
   logic [BYTE_W-1:0]  ks_ff, ks_in;
   logic [BYTE_W-1:0]  out_ff, out_in;

   logic               t_we;
   logic [PERM_AW-1:0] t_waddr, t_raddr;
   logic [BYTE_W-1:0]  t_wdata, t_rdata;
   logic               key_we;
   logic [KAW-1:0]     key_waddr, key_raddr;
   logic [BYTE_W-1:0]  key_rdata;

   logic [BYTE_W-1:0]  i_inc, j_data, mix_j, ks_sum, ks_bypass, ks_sel, result;
   logic               key_room;

   rc4fb_ram #(.WIDTH(BYTE_W), .DEPTH(PERM_DEPTH)) u_perm (
      .clock (clock),
      .we    (t_we),
      .waddr (t_waddr),
      .wdata (t_wdata),
      .raddr (t_raddr),
      .rdata (t_rdata)
   );

   rc4fb_ram #(.WIDTH(BYTE_W), .DEPTH(MAX_KEY_BYTES)) u_key (
      .clock (clock),
      .we    (key_we),
      .waddr (key_waddr),
      .wdata (req_in_byte),
      .raddr (key_raddr),
      .rdata (key_rdata)
   );

   assign i_inc    = i_ff + 8'd1;
   assign j_data   = j_ff + t_rdata;
   assign mix_j    = j_ff + key_rdata + t_rdata;
   assign kidx_inc = kidx_ff + KCW'(1);
   assign key_room = (count_ff < KCW'(MAX_KEY_BYTES));

   // the keystream read was issued before both swap writes had landed
   assign ks_sum    = ti_ff + tj_ff;
   assign ks_bypass = (ks_sum == i_ff) ? tj_ff :
                      (ks_sum == j_ff) ? ti_ff : t_rdata;
   assign ks_sel    = (cmd.op == OP_DATA_OUT) ? ks_bypass : ks_ff;
   assign result    = byte_ff ^ ks_sel ^ fb_ff;

   assign status.k_last   = (k_ff == {PERM_AW{1'b1}});
   assign status.rsp_busy = rsp_valid_ff && !rsp_ready;

   always_comb begin
      t_we      = 1'b0;
      t_waddr   = k_ff;
      t_wdata   = k_ff;
      t_raddr   = i_inc;
      key_we    = 1'b0;
      key_waddr = count_ff[KAW-1:0];
      key_raddr = kidx_ff[KAW-1:0];
      count_in  = count_ff;
      kidx_in   = kidx_ff;
      k_in      = k_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      fb_in     = fb_ff;
      ti_in     = ti_ff;
      tj_in     = tj_ff;
      byte_in   = byte_ff;
      ks_in     = ks_ff;
      case (cmd.op)
         OP_KEY: begin
            if (key_room) begin
               key_we   = 1'b1;
               count_in = count_ff + KCW'(1);
            end
         end
         OP_FILL: begin
            t_we = 1'b1;
            k_in = k_ff + 8'd1;
            j_in = '0;
         end
         OP_MIX_RD: begin
            t_raddr = k_ff;
         end
         OP_MIX_J: begin
            ti_in   = t_rdata;
            j_in    = mix_j;
            t_raddr = mix_j;
         end
         OP_MIX_SW: begin
            t_we    = 1'b1;
            t_wdata = t_rdata;
         end
         OP_MIX_WR: begin
            t_we      = 1'b1;
            t_waddr   = j_ff;
            t_wdata   = ti_ff;
            k_in      = k_ff + 8'd1;
            kidx_in   = (kidx_inc == count_ff) ? '0 : kidx_inc;
            key_raddr = '0;
         end
         OP_FB_LD: begin
            fb_in    = key_rdata;
            i_in     = '0;
            j_in     = '0;
            count_in = '0;
            kidx_in  = '0;
         end
         OP_DATA_START: begin
            byte_in = req_in_byte;
            i_in    = i_inc;
         end
         OP_DATA_J: begin
            ti_in   = t_rdata;
            j_in    = j_data;
            t_raddr = j_data;
         end
         OP_DATA_SWAP: begin
            tj_in   = t_rdata;
            t_we    = 1'b1;
            t_waddr = i_ff;
            t_wdata = t_rdata;
            t_raddr = ti_ff + t_rdata;
         end
         OP_DATA_OUT: begin
            t_we    = 1'b1;
            t_waddr = j_ff;
            t_wdata = ti_ff;
            ks_in   = ks_bypass;
         end
         default: begin
         end
      endcase

      rsp_valid_in = rsp_valid_ff;
      out_in       = out_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
         out_in       = result;
         fb_in        = fb_ff ^ ((dir_ff == DIR_ENCRYPT) ? byte_ff : result);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      dir_in = csr_we ? csr_direction : dir_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         kidx_ff      <= '0;
         k_ff         <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         fb_ff        <= '0;
         dir_ff       <= DIR_DECRYPT;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         kidx_ff      <= kidx_in;
         k_ff         <= k_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         fb_ff        <= fb_in;
         dir_ff       <= dir_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ti_ff   <= ti_in;
      tj_ff   <= tj_in;
      byte_ff <= byte_in;
      ks_ff   <= ks_in;
      out_ff  <= out_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = out_ff;

   `RC4FB_ASSERT_IMPL(a_load_when_free, clock, reset, cmd.load_rsp,
      !(rsp_valid_ff && !rsp_ready), "result loaded over an untaken result")
   `RC4FB_ASSERT_AFTER(a_data_latency, clock, reset, cmd.op == OP_DATA_START, 3,
      cmd.op == OP_DATA_OUT, "data item did not reach the output step")
   `RC4FB_ASSERT_IMPL(a_sched_complete, clock, reset, cmd.op == OP_FB_LD,
      k_ff == '0, "key schedule ended before all table entries were mixed")
   `RC4FB_ASSERT_IMPL(a_kidx_range, clock, reset, cmd.op == OP_MIX_RD,
      kidx_ff < count_ff, "key index outside the loaded key")

endmodule

// ===== rtl/rc4_feedback_stream_cipher.sv =====
// ----------------------------------------------------------------------------
// rc4_feedback_stream_cipher
// rc4-style byte stream cipher with plaintext feedback, top level
// ----------------------------------------------------------------------------
//  channel | ports                                     | moves
//  --------+-------------------------------------------+--------------------------
//  req     | req_valid/ready, kind, in_byte, last      | key or data item in
//  rsp     | rsp_valid/ready, out_byte                 | one item per data item
//  csr     | csr_valid/ready, direction                | direction register write
//
// a data item's result is loaded into the output register in ST_DATA_OUT, or in
// ST_DATA_HOLD while an earlier result stalls; no new item is taken before that
// load, as the single read port of the permutation memory orders the steps (read
// i, read j, swap, keystream read). the final key item then runs the identity fill
// of all 256 entries, a mix step per entry and the feedback load. after reset that
// identity fill runs with req_ready low; csr writes are always taken. a stalled
// result sits in the output register while the next item is accepted.
module rc4_feedback_stream_cipher
   import rc4fb_pkg::*;
#(
   parameter int MAX_KEY_BYTES = DEF_MAX_KEY_BYTES
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_kind,
   input  logic [BYTE_W-1:0] req_in_byte,
   input  logic              req_last,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [BYTE_W-1:0] rsp_out_byte,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_direction
);

   dp_cmd_type    cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   rc4fb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_last  (req_last),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   rc4fb_dp #(.MAX_KEY_BYTES(MAX_KEY_BYTES)) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_in_byte   (req_in_byte),
      .csr_we        (csr_valid && csr_ready),
      .csr_direction (csr_direction),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte)
   );

endmodule

// ===== sim/rc4_feedback_stream_cipher_checker.sv =====
// ----------------------------------------------------------------------------
// rc4 feedback stream cipher checker
// watches the req, rsp and csr channels, keeps its own copy of the permutation,
// key store, indices, feedback byte and direction, predicts every out_byte
// and compares each result item with the oldest prediction
// ----------------------------------------------------------------------------
module rc4_feedback_stream_cipher_checker
   import rc4fb_pkg::*;
#(
   parameter int MAX_KEY_BYTES = DEF_MAX_KEY_BYTES
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic              req_kind,
   input  logic [BYTE_W-1:0] req_in_byte,
   input  logic              req_last,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic [BYTE_W-1:0] rsp_out_byte,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic              csr_direction,
   output int                error_count,
   output int                pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [BYTE_W-1:0] sbox [PERM_DEPTH];
   logic [BYTE_W-1:0] key_bytes [MAX_KEY_BYTES];
   int                key_len;
   logic [BYTE_W-1:0] ptr_i;
   logic [BYTE_W-1:0] ptr_j;
   logic [BYTE_W-1:0] fb_byte;
   logic              dir_mode;
   logic [BYTE_W-1:0] expected_bytes [$];
   int                mismatches;

   function automatic void load_identity();
      for (int k = 0; k < PERM_DEPTH; k++) sbox[k] = BYTE_W'(k);
   endfunction

   // full key schedule over the bytes stored since the last schedule
   function automatic void rekey_sbox();
      logic [BYTE_W-1:0] jj;
      logic [BYTE_W-1:0] tmp;
      load_identity();
      jj = '0;
      for (int k = 0; k < PERM_DEPTH; k++) begin
         jj = jj + key_bytes[k % key_len] + sbox[k];
         tmp = sbox[k];
         sbox[k] = sbox[jj];
         sbox[jj] = tmp;
      end
      fb_byte = key_bytes[0];
      ptr_i = '0;
      ptr_j = '0;
      key_len = 0;
   endfunction

   function automatic logic [BYTE_W-1:0] cipher_byte(logic [BYTE_W-1:0] din);
      logic [BYTE_W-1:0] tmp;
      logic [BYTE_W-1:0] ks_index;
      logic [BYTE_W-1:0] dout;
      ptr_i = ptr_i + 1'b1;
      ptr_j = ptr_j + sbox[ptr_i];
      tmp = sbox[ptr_i];
      sbox[ptr_i] = sbox[ptr_j];
      sbox[ptr_j] = tmp;
      ks_index = sbox[ptr_i] + sbox[ptr_j];
      dout = din ^ sbox[ks_index] ^ fb_byte;
      // plaintext side feeds back: input on encrypt, output on decrypt
      fb_byte = fb_byte ^ ((dir_mode == DIR_ENCRYPT) ? din : dout);
      return dout;
   endfunction

   always @(posedge clock) begin
      logic [BYTE_W-1:0] want;
      if (reset) begin
         load_identity();
         key_len = 0;
         ptr_i = '0;
         ptr_j = '0;
         fb_byte = '0;
         dir_mode = DIR_DECRYPT;
         expected_bytes.delete();
         mismatches = 0;
      end else begin
         if (csr_valid && csr_ready) dir_mode = csr_direction;
         if (rsp_valid && rsp_ready) begin
            if (expected_bytes.size() == 0) begin
               $error("out_byte: expected none, actual 0x%02h", rsp_out_byte);
               mismatches++;
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_out_byte !== want) begin
                  $error("out_byte: expected 0x%02h, actual 0x%02h", want, rsp_out_byte);
                  mismatches++;
               end
            end
         end
         if (req_valid && req_ready) begin
            if (req_kind == KIND_KEY) begin
               // bytes past the store depth are dropped, last still schedules
               if (key_len < MAX_KEY_BYTES) begin
                  key_bytes[key_len] = req_in_byte;
                  key_len++;
               end
               if (req_last) rekey_sbox();
            end else begin
               expected_bytes.push_back(cipher_byte(req_in_byte));
            end
         end
      end
      error_count <= mismatches;
      pending_count <= expected_bytes.size();
   end

endmodule

// ===== sim/rc4_feedback_stream_cipher_test.sv =====
// ----------------------------------------------------------------------------
// rc4 feedback stream cipher testbench
// directed key and data items, then random key loads and data bursts in
// both directions with random gaps and result stalls; the checker predicts
// and compares every result item, this module drives and reports
// ----------------------------------------------------------------------------
module rc4_feedback_stream_cipher_test
   import rc4fb_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD      = 20;
   localparam int RESET_CYCLES    = 9;
   // a final key item keeps the block busy rekeying, with no result
   localparam int DRAIN_CYCLES    = 1400;
   localparam int CYCLE_LIMIT     = 1_000_000;
   localparam int RSP_HOLD_CYCLES = 300;
   localparam int TARGET_ITEMS    = 1600;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic              req_kind;
   logic [BYTE_W-1:0] req_in_byte;
   logic              req_last;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [BYTE_W-1:0] rsp_out_byte;
   logic              csr_valid;
   logic              csr_ready;
   logic              csr_direction;

   int error_count;
   int pending_count;
   int cycle_count;
   int items_sent;
   int key_items;
   int data_items;
   int schedules;
   int overflow_keys;
   int direction_writes;
   int hold_requests;
   int holds_done;

   rc4_feedback_stream_cipher u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_kind      (req_kind),
      .req_in_byte   (req_in_byte),
      .req_last      (req_last),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_direction (csr_direction)
   );

   rc4_feedback_stream_cipher_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_kind      (req_kind),
      .req_in_byte   (req_in_byte),
      .req_last      (req_last),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_direction (csr_direction),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("rc4_feedback_stream_cipher_test: done, errors");
      $finish;
   end

   // result side: short stalls, long stalls, clean stretches, and long holds
   // on request while the sender keeps offering items
   initial begin
      int r;
      int n;
      rsp_ready = 1'b0;
      holds_done = 0;
      @(negedge clock);
      forever begin
         if (holds_done < hold_requests) begin
            rsp_ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(negedge clock);
            holds_done++;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
               rsp_ready <= 1'b1;
               n = $urandom_range(1, 16);
            end else if (r < 70) begin
               rsp_ready <= 1'b1;
               n = $urandom_range(50, 150);
            end else if (r < 95) begin
               rsp_ready <= 1'b0;
               n = $urandom_range(1, 3);
            end else begin
               rsp_ready <= 1'b0;
               n = $urandom_range(10, 40);
            end
            repeat (n) @(negedge clock);
         end
      end
   end

   function automatic int sender_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_item(logic kind, logic [BYTE_W-1:0] value, logic last);
      int gap;
      gap = sender_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_kind    <= kind;
      req_in_byte <= value;
      req_last    <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      items_sent++;
      if (kind == KIND_KEY) begin
         key_items++;
         if (last) schedules++;
      end else begin
         data_items++;
      end
   endtask

   task automatic send_data(int count);
      repeat (count) send_item(KIND_DATA, BYTE_W'($urandom), 1'($urandom));
   endtask

   // noise_pct: chance of a data item slipped in before each key byte
   task automatic send_key(int len, int noise_pct);
      if (len > DEF_MAX_KEY_BYTES) overflow_keys++;
      for (int k = 0; k < len; k++) begin
         if ($urandom_range(0, 99) < noise_pct)
            send_item(KIND_DATA, BYTE_W'($urandom), 1'($urandom));
         send_item(KIND_KEY, BYTE_W'($urandom), k == len - 1);
      end
   endtask

   function automatic int key_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return 1;
      if (r < 60) return $urandom_range(2, 16);
      if (r < 80) return $urandom_range(17, 31);
      if (r < 88) return DEF_MAX_KEY_BYTES;
      return $urandom_range(DEF_MAX_KEY_BYTES + 1, DEF_MAX_KEY_BYTES + 8);
   endfunction

   // wait until every result is back and a rekey could have finished
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_direction(logic dir);
      csr_valid     <= 1'b1;
      csr_direction <= dir;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      direction_writes++;
   endtask

   task automatic run_sequence();
      int r;
      int n;
      r = $urandom_range(0, 99);
      if (r < 80) begin
         send_key(key_length(), 0);
         n = $urandom_range(4, 48);
         if ($urandom_range(0, 19) == 0) begin
            hold_requests++;
            n = 60;
         end
         send_data(n);
      end else if (r < 90) begin
         send_key(key_length(), 25);
         send_data($urandom_range(1, 10));
      end else if (r < 95) begin
         // key bytes with no last: the next key load continues this one
         repeat ($urandom_range(1, 5)) send_item(KIND_KEY, BYTE_W'($urandom), 1'b0);
         send_data($urandom_range(1, 6));
      end else begin
         send_data($urandom_range(1, 8));
      end
   endtask

   initial begin
      logic cur_dir;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_kind      = KIND_KEY;
      req_in_byte   = '0;
      req_last      = 1'b0;
      csr_valid     = 1'b0;
      csr_direction = DIR_DECRYPT;
      items_sent = 0;
      key_items = 0;
      data_items = 0;
      schedules = 0;
      overflow_keys = 0;
      direction_writes = 0;
      hold_requests = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // data before any key runs on the reset permutation
      send_item(KIND_DATA, 8'h00, 1'b0);
      send_item(KIND_DATA, 8'hff, 1'b1);
      send_item(KIND_KEY, 8'hff, 1'b1);
      send_item(KIND_DATA, 8'h00, 1'b0);
      send_item(KIND_DATA, 8'hff, 1'b0);
      send_item(KIND_DATA, 8'h5a, 1'b1);
      settle();
      write_direction(DIR_ENCRYPT);
      send_item(KIND_KEY, 8'h00, 1'b0);
      send_item(KIND_KEY, 8'h5a, 1'b0);
      send_item(KIND_KEY, 8'hff, 1'b1);
      send_item(KIND_DATA, 8'h00, 1'b0);
      send_item(KIND_DATA, 8'hff, 1'b1);
      send_item(KIND_DATA, 8'h3c, 1'b0);
      // data in the middle of a key load uses the old permutation
      send_item(KIND_KEY, 8'h11, 1'b0);
      send_item(KIND_DATA, 8'h80, 1'b0);
      send_item(KIND_KEY, 8'h22, 1'b1);
      send_item(KIND_DATA, 8'h01, 1'b0);
      send_item(KIND_DATA, 8'hfe, 1'b0);
      settle();
      write_direction(DIR_DECRYPT);
      cur_dir = DIR_DECRYPT;

      // first random burst always goes with a long receiver hold
      send_key(key_length(), 0);
      hold_requests++;
      send_data(60);
      while (items_sent < TARGET_ITEMS) begin
         settle();
         if ($urandom_range(0, 3) != 0) cur_dir = ~cur_dir;
         write_direction(cur_dir);
         repeat (6) run_sequence();
      end
      settle();

      $display("covered %0d key items (%0d schedules, %0d overlong keys), %0d data items",
               key_items, schedules, overflow_keys, data_items);
      $display("%0d direction writes, %0d long result holds", direction_writes, holds_done);
      if (error_count == 0)
         $display("rc4_feedback_stream_cipher_test: done, clean");
      else
         $display("rc4_feedback_stream_cipher_test: done, errors");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/rc4fb_pkg.sv
rtl/rc4fb_ram.sv
rtl/rc4fb_ctrl.sv
rtl/rc4fb_dp.sv
rtl/rc4_feedback_stream_cipher.sv
sim/rc4_feedback_stream_cipher_checker.sv
sim/rc4_feedback_stream_cipher_test.sv
